// ===== src/assert_macros.svh =====
// Assertion macros used by the Q-learning engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QLE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define QLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define QLE_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define QLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== src/qle_pkg.sv =====
// Types and constants of the Q-learning engine.
package qle_pkg;

    localparam int NUM_ACTIONS  = 4;
    localparam int ACT_W        = 2;
    localparam int RATE_W       = 16;
    localparam int REWARD_W     = 16;
    localparam int NEW_VALUE_W  = 16;
    localparam int OUT_TDATA_W  = 24;
    localparam int CFG_ADDR_W   = 4;
    localparam int CFG_DATA_W   = 32;

    localparam logic [RATE_W-1:0] LEARNING_RATE_RST = 16'd6554;
    localparam logic [RATE_W-1:0] DISCOUNT_RST      = 16'd58982;
    localparam logic [RATE_W-1:0] EXPLORE_RST       = 16'd6554;

    localparam logic MODE_SELECT = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    typedef enum logic [1:0] {
        REG_LEARNING_RATE = 2'd0,
        REG_DISCOUNT      = 2'd1,
        REG_EXPLORE       = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [RATE_W-1:0] learning_rate;
        logic [RATE_W-1:0] discount;
        logic [RATE_W-1:0] explore_threshold;
    } t_cfg;

    typedef struct packed {
        logic clr_busy;
    } t_tbl_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_TD,
        S_SCALE,
        S_WRITE
    } t_state;

endpackage

// ===== src/qle_cfg.sv =====
// APB configuration registers: learning rate, discount and explore threshold.
module qle_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [qle_pkg::CFG_ADDR_W-1:0]      i_paddr,
    input  logic [qle_pkg::CFG_DATA_W-1:0]      i_pwdata,
    output logic [qle_pkg::CFG_DATA_W-1:0]      o_prdata,
    output logic                                o_pready,
    output qle_pkg::t_cfg                       o_cfg
);

    qle_pkg::t_cfg r_cfg;
    logic          w_wr;

    assign o_pready = 1'b1;
    assign w_wr     = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.learning_rate     <= qle_pkg::LEARNING_RATE_RST;
            r_cfg.discount          <= qle_pkg::DISCOUNT_RST;
            r_cfg.explore_threshold <= qle_pkg::EXPLORE_RST;
        end else if (w_wr) begin
            case (i_paddr[3:2])
                qle_pkg::REG_LEARNING_RATE: r_cfg.learning_rate     <= i_pwdata[15:0];
                qle_pkg::REG_DISCOUNT:      r_cfg.discount          <= i_pwdata[15:0];
                qle_pkg::REG_EXPLORE:       r_cfg.explore_threshold <= i_pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[3:2])
            qle_pkg::REG_LEARNING_RATE: o_prdata = 32'(r_cfg.learning_rate);
            qle_pkg::REG_DISCOUNT:      o_prdata = 32'(r_cfg.discount);
            qle_pkg::REG_EXPLORE:       o_prdata = 32'(r_cfg.explore_threshold);
            default:                    o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/qle_table.sv =====
// Q table memories: action value rows and row valid bits, with valid clear sweep.
module qle_table #(
    parameter int STATE_BITS  = 9,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_rd_en,
    input  logic [STATE_BITS-1:0]                       i_rd_addr_a,
    input  logic [STATE_BITS-1:0]                       i_rd_addr_b,
    input  logic                                        i_wr_en,
    input  logic [STATE_BITS-1:0]                       i_wr_addr,
    input  logic [qle_pkg::NUM_ACTIONS*VALUE_WIDTH-1:0] i_wr_row,
    output logic [qle_pkg::NUM_ACTIONS*VALUE_WIDTH-1:0] o_row_a,
    output logic [qle_pkg::NUM_ACTIONS*VALUE_WIDTH-1:0] o_row_b,
    output logic                                        o_valid_a,
    output logic                                        o_valid_b,
    output qle_pkg::t_tbl_status                        o_status
);

    localparam int ROWS  = 1 << STATE_BITS;
    localparam int ROW_W = qle_pkg::NUM_ACTIONS * VALUE_WIDTH;

    logic [ROW_W-1:0]      r_values [ROWS];
    logic                  r_valid_mem [ROWS];
    logic [ROW_W-1:0]      r_row_a;
    logic [ROW_W-1:0]      r_row_b;
    logic                  r_valid_a;
    logic                  r_valid_b;
    logic                  r_clr_busy;
    logic [STATE_BITS-1:0] r_clr_addr;
    logic                  w_vwr_en;
    logic [STATE_BITS-1:0] w_vwr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {STATE_BITS{1'b1}}) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign w_vwr_en   = r_clr_busy || i_wr_en;
    assign w_vwr_addr = r_clr_busy ? r_clr_addr : i_wr_addr;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_values[i_wr_addr] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_row_a <= r_values[i_rd_addr_a];
            r_row_b <= r_values[i_rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_vwr_en) begin
            r_valid_mem[w_vwr_addr] <= !r_clr_busy;
        end
        if (i_rd_en) begin
            r_valid_a <= r_valid_mem[i_rd_addr_a];
            r_valid_b <= r_valid_mem[i_rd_addr_b];
        end
    end

    assign o_row_a           = r_row_a;
    assign o_row_b           = r_row_b;
    assign o_valid_a         = r_valid_a;
    assign o_valid_b         = r_valid_b;
    assign o_status.clr_busy = r_clr_busy;

endmodule

// ===== src/tabular_q_learning_engine_top.sv =====
// Select: result register loads from S_EVAL after the input transfer; update: through S_EVAL, S_TD, S_SCALE, S_WRITE.
// One item in flight: input is taken only in S_IDLE, so a new item waits until the last one has loaded its result.
// The result register lets the next item enter while a result waits.
// Update cost is set by the table read, two registered multiplies and the row write-back.
// After reset a sweep over all 2**STATE_BITS rows clears the valid memory; tready stays low until it ends.
// Reset sets learning_rate 6554, discount 58982, explore_threshold 6554.
`include "assert_macros.svh"
module tabular_q_learning_engine_top #(
    parameter int STATE_BITS  = 9,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // tdata: state_index, training, random_draw, random_action, taken_action,
    //        reward, next_state_index, zero pad
    input  logic [((2*STATE_BITS+37+7)/8)*8-1:0]    i_s_axis_tdata,
    // tuser: mode
    input  logic                                    i_s_axis_tuser,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // tdata: chosen_action, explored, new_value, zero pad
    output logic [qle_pkg::OUT_TDATA_W-1:0]         o_m_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [qle_pkg::CFG_ADDR_W-1:0]          paddr,
    input  logic [qle_pkg::CFG_DATA_W-1:0]          pwdata,
    output logic [qle_pkg::CFG_DATA_W-1:0]          prdata,
    output logic                                    pready
);

    localparam int VW        = VALUE_WIDTH;
    localparam int ROW_W     = qle_pkg::NUM_ACTIONS * VW;
    localparam int OFF_TRAIN = STATE_BITS;
    localparam int OFF_DRAW  = STATE_BITS + 1;
    localparam int OFF_RACT  = STATE_BITS + 17;
    localparam int OFF_TAKEN = STATE_BITS + 19;
    localparam int OFF_REW   = STATE_BITS + 21;
    localparam int OFF_NEXT  = STATE_BITS + 37;
    localparam int GP_W      = VW + qle_pkg::RATE_W + 1;
    localparam int SUM_W     = ((VW > 16) ? VW : 16) + 2;
    localparam int LP_W      = SUM_W + qle_pkg::RATE_W + 1;
    localparam int NQ_W      = SUM_W + 2;
    localparam int NV_W      = (VW > 16) ? VW : 16;
    localparam logic signed [NQ_W-1:0] SAT_HI = {{(NQ_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [NQ_W-1:0] SAT_LO = {{(NQ_W-VW+1){1'b1}}, {(VW-1){1'b0}}};

    qle_pkg::t_cfg          w_cfg;
    qle_pkg::t_tbl_status   w_tbl_status;
    qle_pkg::t_state        r_state;
    qle_pkg::t_state        n_state;

    logic [ROW_W-1:0]                   w_row_a;
    logic [ROW_W-1:0]                   w_row_b;
    logic                               w_valid_a;
    logic                               w_valid_b;
    logic                               w_s_accept;
    logic                               w_slot_free;
    logic                               w_out_load;
    logic                               w_wr_en;
    logic [ROW_W-1:0]                   w_wr_row;

    logic                               r_mode;
    logic [STATE_BITS-1:0]              r_row_idx;
    logic                               r_training;
    logic [qle_pkg::RATE_W-1:0]         r_draw;
    logic [qle_pkg::ACT_W-1:0]          r_rand_act;
    logic [qle_pkg::ACT_W-1:0]          r_taken;
    logic signed [qle_pkg::REWARD_W-1:0] r_reward;

    logic [qle_pkg::ACT_W-1:0]          w_best_a_idx;
    logic signed [VW-1:0]               w_best_a_val;
    logic signed [VW-1:0]               w_best_b_val;
    logic signed [VW-1:0]               w_maxnext;
    logic signed [VW-1:0]               w_cur;
    logic signed [GP_W-1:0]             w_gamma_prod;
    logic signed [GP_W-1:0]             r_gamma_prod;
    logic signed [SUM_W-1:0]            w_td;
    logic signed [SUM_W-1:0]            r_td;
    logic signed [LP_W-1:0]             w_lr_prod;
    logic signed [LP_W-1:0]             r_lr_prod;
    logic signed [NQ_W-1:0]             w_nq_wide;
    logic signed [VW-1:0]               w_nq;
    logic signed [NV_W-1:0]             w_nv_ext;
    logic                               w_explore;
    logic [qle_pkg::ACT_W-1:0]          w_chosen;

    logic                               r_out_valid;
    logic [qle_pkg::OUT_TDATA_W-1:0]    r_out_data;
    logic [qle_pkg::OUT_TDATA_W-1:0]    n_out_data;

    qle_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    qle_table #(
        .STATE_BITS  (STATE_BITS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (w_s_accept),
        .i_rd_addr_a (i_s_axis_tdata[STATE_BITS-1:0]),
        .i_rd_addr_b (i_s_axis_tdata[OFF_NEXT +: STATE_BITS]),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (r_row_idx),
        .i_wr_row    (w_wr_row),
        .o_row_a     (w_row_a),
        .o_row_b     (w_row_b),
        .o_valid_a   (w_valid_a),
        .o_valid_b   (w_valid_b),
        .o_status    (w_tbl_status)
    );

    // input capture
    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_mode     <= i_s_axis_tuser;
            r_row_idx  <= i_s_axis_tdata[STATE_BITS-1:0];
            r_training <= i_s_axis_tdata[OFF_TRAIN];
            r_draw     <= i_s_axis_tdata[OFF_DRAW +: qle_pkg::RATE_W];
            r_rand_act <= i_s_axis_tdata[OFF_RACT +: qle_pkg::ACT_W];
            r_taken    <= i_s_axis_tdata[OFF_TAKEN +: qle_pkg::ACT_W];
            r_reward   <= $signed(i_s_axis_tdata[OFF_REW +: qle_pkg::REWARD_W]);
        end
    end

    // first maximum of each row
    always_comb begin
        w_best_a_idx = '0;
        w_best_a_val = $signed(w_row_a[VW-1:0]);
        w_best_b_val = $signed(w_row_b[VW-1:0]);
        for (int k = 1; k < qle_pkg::NUM_ACTIONS; k++) begin
            if ($signed(w_row_a[k*VW +: VW]) > w_best_a_val) begin
                w_best_a_val = $signed(w_row_a[k*VW +: VW]);
                w_best_a_idx = qle_pkg::ACT_W'(k);
            end
            if ($signed(w_row_b[k*VW +: VW]) > w_best_b_val) begin
                w_best_b_val = $signed(w_row_b[k*VW +: VW]);
            end
        end
    end

    assign w_explore = (r_training && (r_draw < w_cfg.explore_threshold)) || !w_valid_a;
    assign w_chosen  = w_explore ? r_rand_act : w_best_a_idx;

    // update arithmetic
    always_comb begin
        w_maxnext    = w_valid_b ? w_best_b_val : '0;
        w_cur        = w_valid_a ? $signed(w_row_a[r_taken*VW +: VW]) : '0;
        w_gamma_prod = $signed({1'b0, w_cfg.discount}) * w_maxnext;
        w_td         = SUM_W'(r_reward) + SUM_W'($signed(r_gamma_prod[GP_W-1:16]))
                     - SUM_W'(w_cur);
        w_lr_prod    = $signed({1'b0, w_cfg.learning_rate}) * r_td;
        w_nq_wide    = NQ_W'(w_cur) + NQ_W'($signed(r_lr_prod[LP_W-1:16]));
        if (w_nq_wide > SAT_HI) begin
            w_nq = SAT_HI[VW-1:0];
        end else if (w_nq_wide < SAT_LO) begin
            w_nq = SAT_LO[VW-1:0];
        end else begin
            w_nq = w_nq_wide[VW-1:0];
        end
        w_nv_ext = NV_W'(w_nq);
        w_wr_row = w_valid_a ? w_row_a : '0;
        w_wr_row[r_taken*VW +: VW] = w_nq;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == qle_pkg::S_EVAL) begin
            r_gamma_prod <= w_gamma_prod;
        end
        if (r_state == qle_pkg::S_TD) begin
            r_td <= w_td;
        end
        if (r_state == qle_pkg::S_SCALE) begin
            r_lr_prod <= w_lr_prod;
        end
    end

    assign w_slot_free = !r_out_valid || i_m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            qle_pkg::S_IDLE: begin
                if (w_s_accept) begin
                    n_state = qle_pkg::S_EVAL;
                end
            end
            qle_pkg::S_EVAL: begin
                if (r_mode == qle_pkg::MODE_UPDATE) begin
                    n_state = qle_pkg::S_TD;
                end else if (w_slot_free) begin
                    n_state = qle_pkg::S_IDLE;
                end
            end
            qle_pkg::S_TD:    n_state = qle_pkg::S_SCALE;
            qle_pkg::S_SCALE: n_state = qle_pkg::S_WRITE;
            qle_pkg::S_WRITE: begin
                if (w_slot_free) begin
                    n_state = qle_pkg::S_IDLE;
                end
            end
            default: n_state = qle_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_out_load      = 1'b0;
        w_wr_en         = 1'b0;
        n_out_data      = '0;
        case (r_state)
            qle_pkg::S_IDLE: begin
                o_s_axis_tready = !w_tbl_status.clr_busy;
            end
            qle_pkg::S_EVAL: begin
                if (r_mode == qle_pkg::MODE_SELECT && w_slot_free) begin
                    w_out_load = 1'b1;
                    n_out_data = {{(qle_pkg::OUT_TDATA_W-qle_pkg::ACT_W-1){1'b0}},
                                  w_explore, w_chosen};
                end
            end
            qle_pkg::S_WRITE: begin
                if (w_slot_free) begin
                    w_out_load = 1'b1;
                    w_wr_en    = 1'b1;
                    n_out_data = {{(qle_pkg::OUT_TDATA_W-qle_pkg::NEW_VALUE_W
                                    -qle_pkg::ACT_W-1){1'b0}},
                                  w_nv_ext[qle_pkg::NEW_VALUE_W-1:0], 1'b0,
                                  {qle_pkg::ACT_W{1'b0}}};
                end
            end
            default: ;
        endcase
    end

    assign w_s_accept = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= qle_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `QLE_ASSERT_NOW(a_busy_only_idle, i_clk, i_rst_n,
        w_tbl_status.clr_busy, r_state == qle_pkg::S_IDLE)
    `QLE_ASSERT_NEXT(a_accept_eval, i_clk, i_rst_n,
        w_s_accept, r_state == qle_pkg::S_EVAL)
    `QLE_ASSERT_NEXT(a_write_result, i_clk, i_rst_n,
        w_wr_en, r_out_valid && r_state == qle_pkg::S_IDLE)
    `QLE_ASSERT_NEXT(a_write_holds, i_clk, i_rst_n,
        r_state == qle_pkg::S_WRITE && !w_slot_free, r_state == qle_pkg::S_WRITE)

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the tabular Q-learning engine: table updates, action selection and config registers.
`timescale 1ns / 100ps

module tb;

    localparam int STATE_BITS  = 9;
    localparam int ROWS        = 1 << STATE_BITS;
    localparam int IN_TDATA_W  = ((2*STATE_BITS+37+7)/8)*8;
    localparam int HOT_ROWS    = 16;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic               mode;
        logic [8:0]         state_index;
        logic               training;
        logic [15:0]        random_draw;
        logic [1:0]         random_action;
        logic [1:0]         taken_action;
        logic signed [15:0] reward;
        logic [8:0]         next_state_index;
    } t_agent_step;

    typedef struct {
        logic [1:0]         chosen_action;
        logic               explored;
        logic signed [15:0] new_value;
    } t_engine_outcome;

    logic                               i_clk;
    logic                               i_rst_n;
    logic [IN_TDATA_W-1:0]              s_tdata;
    logic                               s_tuser;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [qle_pkg::OUT_TDATA_W-1:0]    m_tdata;
    logic                               m_tvalid;
    logic                               m_tready;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [qle_pkg::CFG_ADDR_W-1:0]     paddr;
    logic [qle_pkg::CFG_DATA_W-1:0]     pwdata;
    logic [qle_pkg::CFG_DATA_W-1:0]     prdata;
    logic                               pready;

    // shadow of the engine: table, seen bits, rates
    shortint         q_table [0:ROWS-1][0:qle_pkg::NUM_ACTIONS-1];
    bit              row_seen [0:ROWS-1];
    logic [15:0]     alpha_q16;
    logic [15:0]     gamma_q16;
    logic [15:0]     epsilon_q16;

    t_engine_outcome expected_outcomes[$];
    logic [8:0]      hot_rows [0:HOT_ROWS-1];
    int              fail_count;
    int              cycle_count;
    int              hold_cycles;
    bit              src_gaps_on;
    bit              sink_stalls_on;

    tabular_q_learning_engine_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    function automatic logic [1:0] greedy_action(input logic [8:0] row);
        logic [1:0] best;
        best = 2'd0;
        for (int a = 1; a < qle_pkg::NUM_ACTIONS; a++)
            if (q_table[row][a] > q_table[row][best])
                best = a[1:0];
        return best;
    endfunction

    function automatic t_engine_outcome predict_agent_step(input t_agent_step st);
        t_engine_outcome res;
        longint cur;
        longint maxnext;
        longint td;
        longint nq;
        res.chosen_action = 2'd0;
        res.explored      = 1'b0;
        res.new_value     = 16'sd0;
        if (st.mode == qle_pkg::MODE_SELECT) begin
            if ((st.training && st.random_draw < epsilon_q16) || !row_seen[st.state_index]) begin
                res.chosen_action = st.random_action;
                res.explored      = 1'b1;
            end else begin
                res.chosen_action = greedy_action(st.state_index);
            end
        end else begin
            cur = row_seen[st.state_index] ? longint'(q_table[st.state_index][st.taken_action]) : 0;
            maxnext = 0;
            if (row_seen[st.next_state_index])
                maxnext = q_table[st.next_state_index][greedy_action(st.next_state_index)];
            td = longint'(st.reward) + ((longint'(gamma_q16) * maxnext) >>> 16) - cur;
            nq = cur + ((longint'(alpha_q16) * td) >>> 16);
            if (nq > 32767)
                nq = 32767;
            else if (nq < -32768)
                nq = -32768;
            if (!row_seen[st.state_index]) begin
                for (int a = 0; a < qle_pkg::NUM_ACTIONS; a++)
                    q_table[st.state_index][a] = 0;
                row_seen[st.state_index] = 1'b1;
            end
            q_table[st.state_index][st.taken_action] = shortint'(nq);
            res.new_value = nq[15:0];
        end
        return res;
    endfunction

    task automatic send_step(input t_agent_step st);
        int gap;
        @(negedge i_clk);
        if (src_gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tdata  <= IN_TDATA_W'({st.next_state_index, st.reward, st.taken_action,
                                 st.random_action, st.random_draw, st.training,
                                 st.state_index});
        s_tuser  <= st.mode;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        expected_outcomes.push_back(predict_agent_step(st));
    endtask

    task automatic send_select(input logic [8:0] row, input logic training,
                               input logic [15:0] draw, input logic [1:0] ract);
        t_agent_step st;
        st.mode             = qle_pkg::MODE_SELECT;
        st.state_index      = row;
        st.training         = training;
        st.random_draw      = draw;
        st.random_action    = ract;
        st.taken_action     = 2'($urandom);
        st.reward           = 16'($urandom);
        st.next_state_index = 9'($urandom);
        send_step(st);
    endtask

    task automatic send_update(input logic [8:0] row, input logic [1:0] taken,
                               input logic signed [15:0] reward, input logic [8:0] next_row);
        t_agent_step st;
        st.mode             = qle_pkg::MODE_UPDATE;
        st.state_index      = row;
        st.training         = 1'($urandom);
        st.random_draw      = 16'($urandom);
        st.random_action    = 2'($urandom);
        st.taken_action     = taken;
        st.reward           = reward;
        st.next_state_index = next_row;
        send_step(st);
    endtask

    function automatic logic [8:0] pick_row();
        if ($urandom_range(0, 3) == 0)
            return 9'($urandom);
        return hot_rows[$urandom_range(0, HOT_ROWS-1)];
    endfunction

    function automatic t_agent_step random_step();
        t_agent_step st;
        st.mode             = $urandom_range(0, 1) ? qle_pkg::MODE_UPDATE : qle_pkg::MODE_SELECT;
        st.state_index      = pick_row();
        st.training         = 1'($urandom);
        st.random_draw      = 16'($urandom);
        st.random_action    = 2'($urandom);
        st.taken_action     = 2'($urandom);
        if ($urandom_range(0, 3) == 0)
            st.reward = 16'($urandom);
        else
            st.reward = 16'($urandom_range(0, 4095) - 2048);
        st.next_state_index = pick_row();
        return st;
    endfunction

    task automatic wait_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (expected_outcomes.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        fail_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endtask

    task automatic apb_access(input logic wr, input qle_pkg::t_reg_idx idx,
                              input logic [15:0] wval, output logic [15:0] rval);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= qle_pkg::CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= qle_pkg::CFG_DATA_W'(wval);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rval = prdata[15:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_cfg(input qle_pkg::t_reg_idx idx);
        logic [15:0] got;
        logic [15:0] want;
        apb_access(1'b0, idx, 16'd0, got);
        case (idx)
            qle_pkg::REG_LEARNING_RATE: want = alpha_q16;
            qle_pkg::REG_DISCOUNT:      want = gamma_q16;
            default:                    want = epsilon_q16;
        endcase
        if (got !== want)
            report_mismatch("register read", int'(want), int'(got));
    endtask

    task automatic write_cfg(input qle_pkg::t_reg_idx idx, input logic [15:0] val);
        logic [15:0] unused;
        apb_access(1'b1, idx, val, unused);
        case (idx)
            qle_pkg::REG_LEARNING_RATE: alpha_q16   = val;
            qle_pkg::REG_DISCOUNT:      gamma_q16   = val;
            default:                    epsilon_q16 = val;
        endcase
        check_cfg(idx);
    endtask

    always @(posedge i_clk) begin : result_check
        t_engine_outcome want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_outcomes.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result, expected none, actual tdata %h",
                         $time, m_tdata);
            end else begin
                want = expected_outcomes.pop_front();
                if (m_tdata[1:0] !== want.chosen_action)
                    report_mismatch("chosen_action", int'(want.chosen_action),
                                    int'(m_tdata[1:0]));
                if (m_tdata[2] !== want.explored)
                    report_mismatch("explored", int'(want.explored), int'(m_tdata[2]));
                if (m_tdata[18:3] !== want.new_value)
                    report_mismatch("new_value", int'(want.new_value),
                                    int'($signed(m_tdata[18:3])));
            end
        end
    end

    // receiver: random stall bursts, plus a long hold-off on request
    initial begin : sink_ctrl
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 6) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic test_register_reset_values();
        check_cfg(qle_pkg::REG_LEARNING_RATE);
        check_cfg(qle_pkg::REG_DISCOUNT);
        check_cfg(qle_pkg::REG_EXPLORE);
    endtask

    task automatic test_unseen_rows();
        send_select(9'd0,   1'b0, 16'hFFFF, 2'd0);
        send_select(9'd511, 1'b0, 16'hFFFF, 2'd1);
        send_select(9'd511, 1'b1, 16'h0000, 2'd2);
        send_select(9'd170, 1'b1, 16'hFFFF, 2'd3);
        wait_drained();
    endtask

    task automatic test_greedy_and_ties();
        send_update(9'd0,   2'd1, 16'sh7FFF, 9'd511);
        send_select(9'd0,   1'b0, 16'h0000, 2'd3);
        send_update(9'd3,   2'd2, 16'sd256, 9'd0);
        send_select(9'd3,   1'b0, 16'h1234, 2'd0);
        send_update(9'd5,   2'd0, 16'sd0,   9'd5);
        send_select(9'd5,   1'b0, 16'h0000, 2'd3);
        send_update(9'd6,   2'd0, -16'sd32768, 9'd6);
        send_select(9'd6,   1'b0, 16'hFFFF, 2'd0);
        wait_drained();
    endtask

    task automatic test_exploration();
        send_select(9'd0, 1'b1, 16'd6553, 2'd2);
        send_select(9'd0, 1'b1, 16'd6554, 2'd2);
        send_select(9'd0, 1'b0, 16'd0,    2'd3);
        wait_drained();
        write_cfg(qle_pkg::REG_EXPLORE, 16'd0);
        send_select(9'd0, 1'b1, 16'd0, 2'd0);
        wait_drained();
        write_cfg(qle_pkg::REG_EXPLORE, 16'hFFFF);
        send_select(9'd0, 1'b1, 16'hFFFE, 2'd3);
        send_select(9'd0, 1'b1, 16'hFFFF, 2'd3);
        wait_drained();
    endtask

    task automatic test_saturation();
        write_cfg(qle_pkg::REG_LEARNING_RATE, 16'hFFFF);
        write_cfg(qle_pkg::REG_DISCOUNT, 16'hFFFF);
        repeat (3) send_update(9'd7, 2'd3, 16'sh7FFF, 9'd7);
        repeat (3) send_update(9'd8, 2'd0, -16'sd32768, 9'd300);
        send_update(9'd9, 2'd1, -16'sd32768, 9'd8);
        wait_drained();
        write_cfg(qle_pkg::REG_LEARNING_RATE, 16'd0);
        write_cfg(qle_pkg::REG_DISCOUNT, 16'd0);
        send_update(9'd7, 2'd3, -16'sd32768, 9'd7);
        send_update(9'd256, 2'd2, 16'sh7FFF, 9'd7);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_cfg(qle_pkg::REG_LEARNING_RATE, qle_pkg::LEARNING_RATE_RST);
                    write_cfg(qle_pkg::REG_DISCOUNT, qle_pkg::DISCOUNT_RST);
                    write_cfg(qle_pkg::REG_EXPLORE, qle_pkg::EXPLORE_RST);
                end
                1: begin
                    write_cfg(qle_pkg::REG_LEARNING_RATE, 16'hFFFF);
                    write_cfg(qle_pkg::REG_DISCOUNT, 16'd0);
                    write_cfg(qle_pkg::REG_EXPLORE, 16'd0);
                end
                2: begin
                    write_cfg(qle_pkg::REG_LEARNING_RATE, 16'd0);
                    write_cfg(qle_pkg::REG_DISCOUNT, 16'hFFFF);
                    write_cfg(qle_pkg::REG_EXPLORE, 16'hFFFF);
                end
                default: begin
                    write_cfg(qle_pkg::REG_LEARNING_RATE, 16'($urandom));
                    write_cfg(qle_pkg::REG_DISCOUNT, 16'($urandom));
                    write_cfg(qle_pkg::REG_EXPLORE, 16'($urandom));
                end
            endcase
            repeat (240) send_step(random_step());
            wait_drained();
        end
    endtask

    task automatic test_output_backpressure();
        hold_cycles = 400;
        repeat (40) send_step(random_step());
        wait_drained();
    endtask

    task automatic test_full_rate();
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        write_cfg(qle_pkg::REG_LEARNING_RATE, 16'h8000);
        write_cfg(qle_pkg::REG_DISCOUNT, qle_pkg::DISCOUNT_RST);
        write_cfg(qle_pkg::REG_EXPLORE, 16'($urandom));
        repeat (200) send_step(random_step());
        wait_drained();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        s_tvalid       = 1'b0;
        m_tready       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        fail_count     = 0;
        hold_cycles    = 0;
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        alpha_q16      = qle_pkg::LEARNING_RATE_RST;
        gamma_q16      = qle_pkg::DISCOUNT_RST;
        epsilon_q16    = qle_pkg::EXPLORE_RST;
        for (int r = 0; r < ROWS; r++)
            row_seen[r] = 1'b0;
        for (int h = 0; h < HOT_ROWS; h++)
            hot_rows[h] = 9'($urandom);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_register_reset_values();
        test_unseen_rows();
        test_greedy_and_ties();
        test_exploration();
        test_saturation();
        test_random_traffic();
        test_output_backpressure();
        test_full_rate();

        wait_drained();
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/qle_pkg.sv
src/qle_cfg.sv
src/qle_table.sv
src/tabular_q_learning_engine_top.sv
test/tb.sv
